/* sv/assert_macros.svh */
// Assertion macros shared by the RTL modules of the two-class priority FIFO.
// No dependencies; simulation builds get the checks, synthesis gets nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed: condition must never hold");
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_NEVER(lbl, clk, rst, expr)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* sv/tcpf_pkg.sv */
// Package of the two-class priority FIFO: field widths, codes and shared types.
// No dependencies.
package tcpf_pkg;

  localparam int TagW = 16;
  localparam int AgeW = 8;
  localparam int EntryW = TagW + AgeW;

  localparam logic [AgeW-1:0] ThresholdReset = 8'd60;

  typedef enum logic {
    ACT_ENQUEUE = 1'b0,
    ACT_SERVE   = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_QUEUED_PRIO = 3'd0,
    ST_QUEUED_NORM = 3'd1,
    ST_REJECTED    = 3'd2,
    ST_SERVED      = 3'd3,
    ST_EMPTY       = 3'd4
  } status_t;

  // Occupancy flags that a queue reports to the arbiter.
  typedef struct packed {
    logic full;
    logic empty;
  } q_flags_t;

endpackage

/* sv/tcpf_queue.sv */
// One ring queue of the two-class priority FIFO: entry memory, head, tail, count.
// Depends on tcpf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tcpf_queue
  import tcpf_pkg::*;
#(
  parameter int Depth = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [EntryW-1:0] wr_data,
  input  logic              pop,
  output logic [EntryW-1:0] rd_data,
  output q_flags_t          flags
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  logic [EntryW-1:0] mem [Depth];
  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic [CW-1:0] count, count_next;

  assign flags.full  = (count == CW'(Depth));
  assign flags.empty = (count == '0);

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    if (pop) begin
      head_next = (head == AW'(Depth - 1)) ? '0 : head + 1'b1;
    end
    if (push) begin
      tail_next = (tail == AW'(Depth - 1)) ? '0 : tail + 1'b1;
    end
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // Read data is registered on a pop and holds until the next pop.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= wr_data;
    end
    if (pop) begin
      rd_data <= mem[head];
    end
  end

  `ASSERT_NEVER(a_no_pop_empty, clk, rst, pop && flags.empty)
  `ASSERT_NEVER(a_no_push_full, clk, rst, push && flags.full)
  `ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1)

endmodule

/* sv/two_class_priority_fifo_unit.sv */
// Top level of the two-class priority FIFO: classifier, two ring queues, arbiter.
// Depends on tcpf_pkg, tcpf_queue and assert_macros.svh.
//
//  channel | signals                                          | role
//  --------+--------------------------------------------------+--------------------------
//  in      | in_valid, in_ready, action, entry_tag, entry_age | enqueue or serve request
//  out     | out_valid, out_ready, status, served_tag,        | one result per item
//          | served_age, served_from_priority                 |
//  cfg     | cfg_valid, cfg_ready, cfg_data                   | priority age threshold
//
// One item is accepted per cycle while in_ready is high; its result is registered in stage one
// and then in the output register. The queue pointers and counts update at the accepting edge,
// and the entry memory read for a serve is registered there too, so the output stage only forms the result.
// Reset (synchronous, active high) empties both queues and loads a threshold of 60.
// The memory contents are not cleared; only written entries are ever read.
// A stalled output holds its result while one more item can sit in the middle stage;
// in_ready drops only when both stages are full and out_ready is low.

`include "assert_macros.svh"

module two_class_priority_fifo_unit
  import tcpf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 128
) (
  input  logic             clk,
  input  logic             rst,
  // Input item channel.
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             action,
  input  logic [TagW-1:0]  entry_tag,
  input  logic [AgeW-1:0]  entry_age,
  // Result item channel.
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       status,
  output logic [TagW-1:0]  served_tag,
  output logic [AgeW-1:0]  served_age,
  output logic             served_from_priority,
  // Threshold write channel.
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [AgeW-1:0]  cfg_data
);

  // The threshold register accepts a write in any cycle.
  logic [AgeW-1:0] priority_age_threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      priority_age_threshold <= ThresholdReset;
    end else if (cfg_valid && cfg_ready) begin
      priority_age_threshold <= cfg_data;
    end
  end

  // Handshake and pipeline advance. Stage one holds the decision and the queue
  // read data; the output register holds the finished result.
  logic    in_fire;
  logic    s1_valid;
  logic    s1_adv;
  status_t s1_status, s1_status_next;
  logic    s1_from_prio, s1_from_prio_next;

  assign s1_adv   = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_adv;
  assign in_fire  = in_valid && in_ready;

  // Classification and arbitration for the item at the input.
  q_flags_t          prio_flags, norm_flags;
  logic [EntryW-1:0] prio_rd, norm_rd;
  logic              is_serve;
  logic              age_high;
  logic              prio_push, norm_push, prio_pop, norm_pop;
  logic [EntryW-1:0] entry_word;

  assign is_serve   = (action_t'(action) == ACT_SERVE);
  assign age_high   = (entry_age >= priority_age_threshold);
  assign entry_word = {entry_tag, entry_age};

  assign prio_push = in_fire && !is_serve && age_high && !prio_flags.full;
  assign norm_push = in_fire && !is_serve && !age_high && !norm_flags.full;
  // Strict priority: the normal queue is served only while the priority queue is empty.
  assign prio_pop  = in_fire && is_serve && !prio_flags.empty;
  assign norm_pop  = in_fire && is_serve && prio_flags.empty && !norm_flags.empty;

  always_comb begin
    s1_from_prio_next = 1'b0;
    if (!is_serve) begin
      if (age_high) begin
        s1_status_next = prio_flags.full ? ST_REJECTED : ST_QUEUED_PRIO;
      end else begin
        s1_status_next = norm_flags.full ? ST_REJECTED : ST_QUEUED_NORM;
      end
    end else if (!prio_flags.empty) begin
      s1_status_next    = ST_SERVED;
      s1_from_prio_next = 1'b1;
    end else if (!norm_flags.empty) begin
      s1_status_next = ST_SERVED;
    end else begin
      s1_status_next = ST_EMPTY;
    end
  end

  tcpf_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_prio_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (prio_push),
    .wr_data (entry_word),
    .pop     (prio_pop),
    .rd_data (prio_rd),
    .flags   (prio_flags)
  );

  tcpf_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_norm_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (norm_push),
    .wr_data (entry_word),
    .pop     (norm_pop),
    .rd_data (norm_rd),
    .flags   (norm_flags)
  );

  // Stage one registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_status    <= s1_status_next;
      s1_from_prio <= s1_from_prio_next;
    end
  end

  // The queue read registers hold until the next pop, so the served entry stays
  // available however long stage one stalls.
  logic [EntryW-1:0] served_word;
  logic              s1_served;

  assign served_word = s1_from_prio ? prio_rd : norm_rd;
  assign s1_served   = (s1_status == ST_SERVED);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      status               <= s1_status;
      served_tag           <= s1_served ? served_word[EntryW-1:AgeW] : '0;
      served_age           <= s1_served ? served_word[AgeW-1:0] : '0;
      served_from_priority <= s1_from_prio;
    end
  end

  `ASSERT_NEVER(a_one_pop, clk, rst, prio_pop && norm_pop)
  `ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && !s1_adv, s1_valid)
  `ASSERT_IMPLY(a_prio_served, clk, rst, out_valid && served_from_priority, status == ST_SERVED)
  `ASSERT_IMPLY(a_zero_unserved, clk, rst, out_valid && status != ST_SERVED, served_tag == '0 && served_age == '0)

endmodule
